/* sv/kbt_pkg.sv */
// ---------------------------------------------------------------------------
// kbt_pkg
// shared types and codes for the key binding table
// ---------------------------------------------------------------------------
package kbt_pkg;

  // request codes
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_BIND   = 2'd1;
  localparam logic [1:0] MODE_UNBIND = 2'd2;

  // result codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  localparam int KEY_W     = 16;
  localparam int HANDLER_W = 16;
  localparam int ENTRY_W   = KEY_W + HANDLER_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RESP
  } kbt_state_t;

endpackage

/* sv/key_binding_table_top.sv */
// ---------------------------------------------------------------------------
// key_binding_table_top
// packed key-to-handler table with lookup, bind and unbind requests
// ---------------------------------------------------------------------------
// The table lives in one synchronous memory of TABLE_DEPTH entries, each a
// key and its handler, with a single read and a single write port. A request
// is taken only while the block is idle and gives exactly one result item.
// The search reads one entry per cycle, up to the first match or over all
// entries on a miss. An unbind that hits then moves each later entry down one
// place through the same read port. The result sits in an output register,
// so the next request can be taken while it waits.
module key_binding_table_top #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  // mode [1:0], key [17:2], handler [33:18], zero pad above
  input  logic [kbt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // status [1:0], found [2], handler_out [18:3], zero pad above
  output logic [kbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = kbt_pkg::KEY_W;
  localparam int HW = kbt_pkg::HANDLER_W;
  localparam int EW = kbt_pkg::ENTRY_W;

  // table memory: key in the upper half, handler in the lower half
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rdata;

  kbt_pkg::kbt_state_t state, state_next;

  logic [1:0]    req_mode;
  logic [KW-1:0] req_key;
  logic [HW-1:0] req_handler;
  logic [CW-1:0] count;
  logic [CW-1:0] ridx;
  logic [AW-1:0] cidx;
  logic          cvalid;

  logic [1:0]    res_status;
  logic          res_found;
  logic [HW-1:0] res_handler;

  logic          out_valid;
  logic [1:0]    out_status;
  logic          out_found;
  logic [HW-1:0] out_handler;

  logic          s_accept;
  logic          match;
  logic          scan_end;
  logic          full;
  logic          out_free;

  logic          issue;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          count_inc;
  logic          count_dec;
  logic          res_load;
  logic [1:0]    res_status_next;
  logic [HW-1:0] res_handler_next;

  assign s_axis_tready = (state == kbt_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign match         = cvalid && (rdata[EW-1:HW] == req_key);
  // every issued read has come back and nothing is left to read
  assign scan_end      = !cvalid && (ridx >= count);
  assign full          = (count == CW'(TABLE_DEPTH));
  assign out_free      = !out_valid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kbt_pkg::ST_IDLE: begin
        if (s_accept) state_next = kbt_pkg::ST_SEARCH;
      end
      kbt_pkg::ST_SEARCH: begin
        if (match) begin
          state_next = (req_mode == kbt_pkg::MODE_UNBIND) ? kbt_pkg::ST_SHIFT
                                                          : kbt_pkg::ST_RESP;
        end else if (scan_end) begin
          state_next = kbt_pkg::ST_RESP;
        end
      end
      kbt_pkg::ST_SHIFT: begin
        if (scan_end) state_next = kbt_pkg::ST_RESP;
      end
      kbt_pkg::ST_RESP: begin
        if (out_free) state_next = kbt_pkg::ST_IDLE;
      end
      default: state_next = kbt_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    issue            = 1'b0;
    we               = 1'b0;
    wr_addr          = '0;
    wr_data          = '0;
    count_inc        = 1'b0;
    count_dec        = 1'b0;
    res_load         = 1'b0;
    res_status_next  = kbt_pkg::STATUS_OK;
    res_handler_next = '0;
    case (state)
      kbt_pkg::ST_SEARCH: begin
        issue = (ridx < count);
        if (match) begin
          res_load = 1'b1;
          case (req_mode)
            kbt_pkg::MODE_LOOKUP: begin
              res_handler_next = rdata[HW-1:0];
            end
            kbt_pkg::MODE_BIND: begin
              if (full) begin
                res_status_next = kbt_pkg::STATUS_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = cidx;
                wr_data = {req_key, req_handler};
              end
            end
            default: ;
          endcase
        end else if (scan_end) begin
          res_load = 1'b1;
          case (req_mode)
            kbt_pkg::MODE_LOOKUP: res_status_next = kbt_pkg::STATUS_MISS;
            kbt_pkg::MODE_UNBIND: res_status_next = kbt_pkg::STATUS_MISS;
            kbt_pkg::MODE_BIND: begin
              if (full) begin
                res_status_next = kbt_pkg::STATUS_FULL;
              end else begin
                // append at the end
                we        = 1'b1;
                wr_addr   = count[AW-1:0];
                wr_data   = {req_key, req_handler};
                count_inc = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      kbt_pkg::ST_SHIFT: begin
        issue = (ridx < count);
        if (cvalid) begin
          // entry read last cycle moves down one place
          we      = 1'b1;
          wr_addr = cidx - 1'b1;
          wr_data = rdata;
        end
        if (scan_end) count_dec = 1'b1;
      end
      default: ;
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (issue) rdata <= mem[ridx[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kbt_pkg::ST_IDLE;
      count     <= '0;
      ridx      <= '0;
      cvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (count_inc) count <= count + 1'b1;
      else if (count_dec) count <= count - 1'b1;

      if (s_accept) begin
        ridx   <= '0;
        cvalid <= 1'b0;
      end else if (state == kbt_pkg::ST_SEARCH && match &&
                   req_mode == kbt_pkg::MODE_UNBIND) begin
        // shift starts at the entry after the hit
        ridx   <= CW'(cidx) + 1'b1;
        cvalid <= 1'b0;
      end else begin
        if (issue) ridx <= ridx + 1'b1;
        cvalid <= issue;
      end

      if (state == kbt_pkg::ST_RESP && out_free) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_mode    <= s_axis_tdata[1:0];
      req_key     <= s_axis_tdata[2 +: KW];
      req_handler <= s_axis_tdata[2 + KW +: HW];
    end
    if (issue) cidx <= ridx[AW-1:0];
    if (res_load) begin
      res_status  <= res_status_next;
      res_found   <= match;
      res_handler <= res_handler_next;
    end
    if (state == kbt_pkg::ST_RESP && out_free) begin
      out_status  <= res_status;
      out_found   <= res_found;
      out_handler <= res_handler;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(kbt_pkg::OUT_TDATA_W - HW - 3){1'b0}},
                          out_handler, out_found, out_status};

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// drives lookup, bind and unbind requests into key_binding_table_top and
// checks every result item against a predictor that keeps its own copy of
// the table, with random idling on both sides, a long output hold-off and
// phases that fill the table to full and drain it back to empty
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = 128;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;

  // the request code left over in the two-bit field, taken as no operation
  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] handler_out;
  } binding_result_t;

  logic clk;
  logic rst;
  logic [kbt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [kbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;

  // predictor copy of the table
  logic [15:0] tbl_keys [TABLE_DEPTH];
  logic [15:0] tbl_handlers [TABLE_DEPTH];
  int          tbl_count = 0;

  binding_result_t pending_results [$];
  int mismatch_count = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  key_binding_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic binding_result_t update_binding_table(input logic [1:0] mode,
                                                           input logic [15:0] key,
                                                           input logic [15:0] handler);
    binding_result_t res;
    int pos;
    pos = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (pos < 0 && tbl_keys[i] == key) pos = i;
    end
    res.status      = kbt_pkg::STATUS_OK;
    res.found       = (pos >= 0);
    res.handler_out = '0;
    case (mode)
      kbt_pkg::MODE_LOOKUP: begin
        if (pos >= 0) res.handler_out = tbl_handlers[pos];
        else res.status = kbt_pkg::STATUS_MISS;
      end
      kbt_pkg::MODE_BIND: begin
        // a full table refuses even a key that is already bound
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = kbt_pkg::STATUS_FULL;
        end else if (pos >= 0) begin
          tbl_handlers[pos] = handler;
        end else begin
          tbl_keys[tbl_count]     = key;
          tbl_handlers[tbl_count] = handler;
          tbl_count++;
        end
      end
      kbt_pkg::MODE_UNBIND: begin
        if (pos < 0) begin
          res.status = kbt_pkg::STATUS_MISS;
        end else begin
          for (int i = pos; i < tbl_count - 1; i++) begin
            tbl_keys[i]     = tbl_keys[i + 1];
            tbl_handlers[i] = tbl_handlers[i + 1];
          end
          tbl_count--;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // a bound key for hit_pct percent of picks, otherwise a random one with the extremes mixed in
  function automatic logic [15:0] pick_key(input int hit_pct);
    int sel;
    if (tbl_count > 0 && $urandom_range(0, 99) < hit_pct)
      return tbl_keys[$urandom_range(0, tbl_count - 1)];
    sel = $urandom_range(0, 19);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] pick_handler();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  task automatic send_request(input logic [1:0] mode, input logic [15:0] key,
                              input logic [15:0] handler);
    binding_result_t want;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_axis_tdata  = {6'd0, handler, key, mode};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    want = update_binding_table(mode, key, handler);
    pending_results.push_back(want);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // weights are percent; whatever is left over goes to no-operation items
  task automatic run_random_requests(input int n_items, input int w_lookup, input int w_bind,
                                     input int w_unbind, input int hit_pct);
    int roll;
    logic [1:0] mode;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < w_lookup) mode = kbt_pkg::MODE_LOOKUP;
      else if (roll < w_lookup + w_bind) mode = kbt_pkg::MODE_BIND;
      else if (roll < w_lookup + w_bind + w_unbind) mode = kbt_pkg::MODE_UNBIND;
      else mode = MODE_NOP;
      send_request(mode, pick_key(hit_pct), pick_handler());
    end
  endtask

  task automatic test_directed_cases();
    send_request(kbt_pkg::MODE_LOOKUP, 16'h0000, 16'hFFFF);  // miss on empty table
    send_request(kbt_pkg::MODE_UNBIND, 16'hFFFF, 16'h0000);  // unbind miss on empty table
    send_request(MODE_NOP,             16'h1234, 16'hABCD);
    send_request(kbt_pkg::MODE_BIND,   16'h0000, 16'hFFFF);
    send_request(kbt_pkg::MODE_BIND,   16'hFFFF, 16'h0000);
    send_request(kbt_pkg::MODE_LOOKUP, 16'h0000, 16'h0000);
    send_request(kbt_pkg::MODE_LOOKUP, 16'hFFFF, 16'hFFFF);
    send_request(kbt_pkg::MODE_BIND,   16'h0000, 16'h5A5A);  // update in place
    send_request(kbt_pkg::MODE_LOOKUP, 16'h0000, 16'h0000);
    send_request(MODE_NOP,             16'h0000, 16'h0000);  // ignored but reports a hit
    send_request(kbt_pkg::MODE_BIND,   16'h8000, 16'h7FFF);
    send_request(kbt_pkg::MODE_BIND,   16'h0001, 16'hA5A5);
    send_request(kbt_pkg::MODE_UNBIND, 16'h0000, 16'h0000);  // first entry, rest shift down
    send_request(kbt_pkg::MODE_LOOKUP, 16'h0000, 16'h0000);
    send_request(kbt_pkg::MODE_LOOKUP, 16'hFFFF, 16'h0000);
    send_request(kbt_pkg::MODE_LOOKUP, 16'h8000, 16'h0000);
    send_request(kbt_pkg::MODE_UNBIND, 16'h0001, 16'h0000);  // last entry
    send_request(kbt_pkg::MODE_UNBIND, 16'h8000, 16'h0000);
    send_request(kbt_pkg::MODE_LOOKUP, 16'h8000, 16'h0000);
    send_request(kbt_pkg::MODE_UNBIND, 16'hFFFF, 16'h0000);  // table empty again
    send_request(kbt_pkg::MODE_UNBIND, 16'hFFFF, 16'h0000);
    wait_for_results();
  endtask

  task automatic test_mixed_traffic();
    run_random_requests(500, 40, 35, 23, 60);
    wait_for_results();
  endtask

  task automatic test_fill_to_full();
    // binds outrun unbinds so the table fills, then full binds keep hitting
    run_random_requests(330, 15, 82, 2, 20);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    run_random_requests(40, 40, 35, 23, 60);
    wait_for_results();
  endtask

  task automatic test_drain_to_empty();
    run_random_requests(300, 20, 8, 70, 85);
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    run_random_requests(480, 40, 35, 23, 60);
    wait_for_results();
  endtask

  // result receiver
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    binding_result_t want;
    binding_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status      = m_axis_tdata[1:0];
      got.found       = m_axis_tdata[2];
      got.handler_out = m_axis_tdata[18:3];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item: status %0d found %0d handler_out %h",
                   got.status, got.found, got.handler_out);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.found != want.found ||
            got.handler_out != want.handler_out) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d found %0d handler_out %h",
                     want.status, want.found, want.handler_out);
            $display("          got      status %0d found %0d handler_out %h",
                     got.status, got.found, got.handler_out);
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst == 1'b0);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_mixed_traffic();
    test_fill_to_full();
    test_output_backpressure();
    test_drain_to_empty();
    test_back_to_back();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

/* key_binding_table_top.f */
sv/kbt_pkg.sv
sv/key_binding_table_top.sv
tb/testbench.sv
